// ===== hw/rtl/pnq_pkg.sv =====
// shared constants and types of the palette nearest color quantizer
package pnq_pkg;

  localparam int MAX_COLORS = 16;
  localparam int MAX_SHADES = 16;
  localparam int SLOT_LIMIT = 16;

  localparam int SLOT_W  = 4;
  localparam int CODE_W  = 5;
  localparam int COMP_W  = 8;
  localparam int SQ_W    = 2 * COMP_W;
  localparam int DIST_W  = SQ_W + 2;
  localparam int ENTRIES = SLOT_LIMIT * SLOT_LIMIT;
  localparam int ADDR_W  = $clog2(ENTRIES);

  localparam logic [1:0] FUNC_CLEAR    = 2'd0;
  localparam logic [1:0] FUNC_LOAD     = 2'd1;
  localparam logic [1:0] FUNC_CLASSIFY = 2'd2;

  typedef struct packed {
    logic [COMP_W-1:0] alpha;
    logic [COMP_W-1:0] blue;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] red;
  } rgba_t;

endpackage

// ===== hw/rtl/pnq_if.sv =====
// input and result channel interfaces of the quantizer
interface pnq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  color_slot;
  logic [3:0]  shade_slot;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;

  modport source (
    output valid, func, color_slot, shade_slot, red, green, blue, alpha,
    input  ready
  );
  modport sink (
    input  valid, func, color_slot, shade_slot, red, green, blue, alpha,
    output ready
  );
endinterface

interface pnq_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  color_code;
  logic [4:0]  shade_code;

  modport source (
    output valid, color_code, shade_code,
    input  ready
  );
  modport sink (
    input  valid, color_code, shade_code,
    output ready
  );
endinterface

// ===== hw/rtl/pnq_ram.sv =====
// generic single write port ram with registered read
module pnq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pnq_dist.sv =====
// squared rgba distance unit, squares registered, sum combinational
module pnq_dist (
  input  logic                      clk_i,
  input  pnq_pkg::rgba_t            entry_i,
  input  pnq_pkg::rgba_t            pixel_i,
  output logic [pnq_pkg::DIST_W-1:0] dist_o
);

  function automatic logic [pnq_pkg::COMP_W-1:0] abs_diff(
    input logic [pnq_pkg::COMP_W-1:0] a,
    input logic [pnq_pkg::COMP_W-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  logic [pnq_pkg::COMP_W-1:0] diff [4];
  logic [pnq_pkg::SQ_W-1:0]   sq_q [4];

  always_comb begin
    diff[0] = abs_diff(entry_i.red,   pixel_i.red);
    diff[1] = abs_diff(entry_i.green, pixel_i.green);
    diff[2] = abs_diff(entry_i.blue,  pixel_i.blue);
    diff[3] = abs_diff(entry_i.alpha, pixel_i.alpha);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      sq_q[i] <= pnq_pkg::SQ_W'(diff[i]) * pnq_pkg::SQ_W'(diff[i]);
    end
  end

  assign dist_o = pnq_pkg::DIST_W'(sq_q[0]) + pnq_pkg::DIST_W'(sq_q[1])
                + pnq_pkg::DIST_W'(sq_q[2]) + pnq_pkg::DIST_W'(sq_q[3]);

endmodule

// ===== hw/rtl/palette_nearest_color_quantizer.sv =====
// top level of the palette nearest color quantizer
//
//   channel  dir  word                                              handshake
//   in_i     in   func, color_slot, shade_slot, red, green, blue, alpha  valid/ready
//   out_o    out  color_code, shade_code                            valid/ready
//
// clear and load words take effect without leaving the idle state
// a classify word scans all 256 palette entries through one distance unit,
// one entry a cycle; a pixel with alpha zero skips the scan and gets code zero
// reset clears the valid marks at once; palette contents stay undefined
// a finished result waits in the output register; clear and load words are
// still taken meanwhile, a further classify holds its result until it drains
module palette_nearest_color_quantizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  pnq_in_if.sink        in_i,
  pnq_out_if.source     out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [pnq_pkg::ENTRIES-1:0] valid_q;
  logic [pnq_pkg::ADDR_W-1:0]  addr_q;
  logic [pnq_pkg::ADDR_W-1:0]  p1_addr_q;
  logic [pnq_pkg::ADDR_W-1:0]  p2_addr_q;
  logic [pnq_pkg::ADDR_W-1:0]  best_addr_q;
  logic [pnq_pkg::DIST_W-1:0]  best_dist_q;
  logic [pnq_pkg::DIST_W-1:0]  cur_dist;
  logic                        p1_vld_q, p1_ok_q;
  logic                        p2_vld_q, p2_ok_q;
  logic                        found_q;
  logic                        out_vld_q;
  logic [pnq_pkg::CODE_W-1:0]  color_code_q, shade_code_q;
  pnq_pkg::rgba_t              pix_q;
  pnq_pkg::rgba_t              in_rgba;
  pnq_pkg::rgba_t              entry;
  logic [31:0]                 rdata;

  logic                        in_acc;
  logic                        load_we;
  logic [pnq_pkg::ADDR_W-1:0]  load_addr;
  logic                        better;
  logic                        out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign in_rgba.red   = in_i.red;
  assign in_rgba.green = in_i.green;
  assign in_rgba.blue  = in_i.blue;
  assign in_rgba.alpha = in_i.alpha;

  assign load_addr = {in_i.color_slot, in_i.shade_slot};
  assign load_we   = in_acc && (in_i.func == pnq_pkg::FUNC_LOAD)
                  && (32'(in_i.color_slot) < pnq_pkg::MAX_COLORS)
                  && (32'(in_i.shade_slot) < pnq_pkg::MAX_SHADES);

  pnq_ram #(
    .WIDTH (32),
    .DEPTH (pnq_pkg::ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (load_addr),
    .wdata_i (in_rgba),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign entry = rdata;

  pnq_dist u_dist (
    .clk_i   (clk_i),
    .entry_i (entry),
    .pixel_i (pix_q),
    .dist_o  (cur_dist)
  );

  assign better   = p2_vld_q && p2_ok_q && (!found_q || (cur_dist < best_dist_q));
  assign out_free = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_i.func == pnq_pkg::FUNC_CLASSIFY)) begin
      pix_q <= in_rgba;
    end
    p1_addr_q <= addr_q;
    p2_addr_q <= p1_addr_q;
    if (better) begin
      best_dist_q <= cur_dist;
      best_addr_q <= p2_addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      p1_vld_q <= 1'b0;
      p1_ok_q  <= 1'b0;
      p2_vld_q <= 1'b0;
      p2_ok_q  <= 1'b0;
    end else begin
      if (in_acc && (in_i.func == pnq_pkg::FUNC_CLEAR)) begin
        valid_q <= '0;
      end else if (load_we) begin
        valid_q[load_addr] <= 1'b1;
      end
      p1_vld_q <= (state_q == ST_SCAN);
      p1_ok_q  <= valid_q[addr_q];
      p2_vld_q <= p1_vld_q;
      p2_ok_q  <= p1_ok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      addr_q       <= '0;
      found_q      <= 1'b0;
      out_vld_q    <= 1'b0;
      color_code_q <= '0;
      shade_code_q <= '0;
    end else begin
      if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (better) begin
        found_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_i.func == pnq_pkg::FUNC_CLASSIFY)) begin
            found_q <= 1'b0;
            addr_q  <= '0;
            state_q <= (in_i.alpha == '0) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == pnq_pkg::ADDR_W'(pnq_pkg::ENTRIES - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!p1_vld_q && !p2_vld_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            if (found_q) begin
              color_code_q <= pnq_pkg::CODE_W'(
                best_addr_q[pnq_pkg::ADDR_W-1 -: pnq_pkg::SLOT_W]) + 1'b1;
              shade_code_q <= pnq_pkg::CODE_W'(
                best_addr_q[pnq_pkg::SLOT_W-1:0]) + 1'b1;
            end else begin
              color_code_q <= '0;
              shade_code_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.color_code = color_code_q;
  assign out_o.shade_code = shade_code_q;

endmodule

// ===== hw/rtl/pnq_checker.sv =====
// port level checks of the quantizer and their bind
module pnq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_func_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] color_code_i,
  input logic [4:0] shade_code_i
);

  // ready is low in the cycle after a classify word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i == pnq_pkg::FUNC_CLASSIFY) |=> !in_ready_i)
    else $error("ready after classify word");

  // a stalled result word stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(color_code_i)
      && $stable(shade_code_i))
    else $error("stalled result word changed");

  // color and shade codes are zero together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((color_code_i == '0) == (shade_code_i == '0)))
    else $error("codes disagree on none");

  // codes stay within the palette size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (32'(color_code_i) <= pnq_pkg::MAX_COLORS)
      && (32'(shade_code_i) <= pnq_pkg::MAX_SHADES))
    else $error("code out of range");

endmodule

bind palette_nearest_color_quantizer pnq_checker u_pnq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_func_i    (in_i.func),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .color_code_i (out_o.color_code),
  .shade_code_i (out_o.shade_code)
);

// ===== bench/testbench.sv =====
// self-checking testbench of the palette nearest color quantizer
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1850;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [1:0]                 func;
    logic [pnq_pkg::SLOT_W-1:0] color_slot;
    logic [pnq_pkg::SLOT_W-1:0] shade_slot;
    pnq_pkg::rgba_t             px;
  } pixel_word_t;

  typedef struct packed {
    logic [pnq_pkg::CODE_W-1:0] color_code;
    logic [pnq_pkg::CODE_W-1:0] shade_code;
  } code_pair_t;

  typedef struct {
    pixel_word_t w;
    bit          typed;
    code_pair_t  code;
  } script_row_t;

  logic clk_i;
  logic rst_ni;

  pnq_in_if  in_ch ();
  pnq_out_if out_ch ();

  palette_nearest_color_quantizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  pnq_pkg::rgba_t shadow_rgba [pnq_pkg::SLOT_LIMIT][pnq_pkg::SLOT_LIMIT];
  bit             shadow_valid [pnq_pkg::SLOT_LIMIT][pnq_pkg::SLOT_LIMIT];
  code_pair_t     pending_codes [$];
  script_row_t    directed_rows [$];
  bit             typed_pending;
  code_pair_t     typed_code;
  int             fail_cnt = 0;
  int             cycle_cnt = 0;
  int             burst_left = 0;
  int             sink_mode = 0;
  int             window_left = 0;
  int             run_left = 0;

  function automatic int unsigned sq_diff(input logic [pnq_pkg::COMP_W-1:0] a,
                                          input logic [pnq_pkg::COMP_W-1:0] b);
    int unsigned d;
    d = (a >= b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  function automatic code_pair_t nearest_entry(input pnq_pkg::rgba_t px);
    code_pair_t  best;
    int unsigned best_d;
    int unsigned d;
    bit          found;
    best = '0;
    best_d = 0;
    found = 1'b0;
    if (px.alpha != 0) begin
      for (int c = 0; c < pnq_pkg::SLOT_LIMIT && c < pnq_pkg::MAX_COLORS; c++) begin
        for (int s = 0; s < pnq_pkg::SLOT_LIMIT && s < pnq_pkg::MAX_SHADES; s++) begin
          if (shadow_valid[c][s]) begin
            d = sq_diff(shadow_rgba[c][s].red, px.red)
              + sq_diff(shadow_rgba[c][s].green, px.green)
              + sq_diff(shadow_rgba[c][s].blue, px.blue)
              + sq_diff(shadow_rgba[c][s].alpha, px.alpha);
            if (!found || d < best_d) begin
              found = 1'b1;
              best_d = d;
              best.color_code = pnq_pkg::CODE_W'(c + 1);
              best.shade_code = pnq_pkg::CODE_W'(s + 1);
            end
          end
        end
      end
    end
    return best;
  endfunction

  // shadow palette follows every accepted word, results are checked in order
  always @(posedge clk_i) begin
    code_pair_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.func)
          pnq_pkg::FUNC_CLEAR: begin
            foreach (shadow_valid[c, s]) shadow_valid[c][s] = 1'b0;
          end
          pnq_pkg::FUNC_LOAD: begin
            if (in_ch.color_slot < pnq_pkg::MAX_COLORS
                && in_ch.shade_slot < pnq_pkg::MAX_SHADES) begin
              shadow_rgba[in_ch.color_slot][in_ch.shade_slot] =
                {in_ch.alpha, in_ch.blue, in_ch.green, in_ch.red};
              shadow_valid[in_ch.color_slot][in_ch.shade_slot] = 1'b1;
            end
          end
          pnq_pkg::FUNC_CLASSIFY: begin
            if (typed_pending) pending_codes.push_back(typed_code);
            else pending_codes.push_back(nearest_entry({in_ch.alpha, in_ch.blue,
                                                        in_ch.green, in_ch.red}));
          end
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_codes.size() == 0) begin
          $error("color_code: expected none, actual %0d (shade_code %0d)",
                 out_ch.color_code, out_ch.shade_code);
          fail_cnt++;
        end else begin
          want = pending_codes.pop_front();
          if (out_ch.color_code !== want.color_code) begin
            $error("color_code: expected %0d, actual %0d", want.color_code, out_ch.color_code);
            fail_cnt++;
          end
          if (out_ch.shade_code !== want.shade_code) begin
            $error("shade_code: expected %0d, actual %0d", want.shade_code, out_ch.shade_code);
            fail_cnt++;
          end
        end
      end
    end
  end

  // receiver stalls in windows of changing style
  always @(posedge clk_i) begin
    if (window_left == 0) begin
      sink_mode <= $urandom_range(0, 3);
      window_left <= $urandom_range(100, 600);
    end else begin
      window_left <= window_left - 1;
    end
    if (run_left == 0) begin
      case (sink_mode)
        0: begin
          out_ch.ready <= 1'b1;
          run_left <= 0;
        end
        1: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
          run_left <= $urandom_range(0, 2);
        end
        2: begin
          out_ch.ready <= !out_ch.ready;
          run_left <= out_ch.ready ? $urandom_range(2, 8) : 0;
        end
        default: begin
          out_ch.ready <= !out_ch.ready;
          run_left <= out_ch.ready ? $urandom_range(10, 40) : $urandom_range(0, 3);
        end
      endcase
    end else begin
      run_left <= run_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_row(input logic [1:0] func, input int cs, input int ss,
                         input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                         input logic [7:0] a, input bit typed, input int cc, input int sc);
    script_row_t row;
    row.w.func = func;
    row.w.color_slot = pnq_pkg::SLOT_W'(cs);
    row.w.shade_slot = pnq_pkg::SLOT_W'(ss);
    row.w.px = {a, b, g, r};
    row.typed = typed;
    row.code.color_code = pnq_pkg::CODE_W'(cc);
    row.code.shade_code = pnq_pkg::CODE_W'(sc);
    directed_rows.push_back(row);
  endtask

  // offers one word, waits for it to be taken, then maybe idles
  task automatic send_word(input pixel_word_t w, input bit typed, input code_pair_t code);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.func <= w.func;
    in_ch.color_slot <= w.color_slot;
    in_ch.shade_slot <= w.shade_slot;
    in_ch.red <= w.px.red;
    in_ch.green <= w.px.green;
    in_ch.blue <= w.px.blue;
    in_ch.alpha <= w.px.alpha;
    typed_pending <= typed;
    typed_code <= code;
    do @(posedge clk_i); while (!in_ch.ready);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_codes.size() != 0);
  endtask

  function automatic logic [7:0] pick_comp(input bit coarse);
    logic [7:0] v;
    case ($urandom_range(0, 7))
      0: v = 8'h00;
      1: v = 8'hff;
      default: v = coarse ? ($urandom_range(0, 1) ? 8'h80 : 8'h00) : 8'($urandom);
    endcase
    return v;
  endfunction

  function automatic pnq_pkg::rgba_t pick_rgba(input bit coarse);
    pnq_pkg::rgba_t v;
    v.red = pick_comp(coarse);
    v.green = pick_comp(coarse);
    v.blue = pick_comp(coarse);
    v.alpha = pick_comp(coarse);
    return v;
  endfunction

  function automatic logic [7:0] jitter(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 6)) - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  initial begin
    pixel_word_t    w;
    pnq_pkg::rgba_t loaded [$];
    pnq_pkg::rgba_t e;
    bit             coarse;
    int             sent;
    int             episode;
    int             n_load;
    int             n_cls;

    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= pnq_pkg::FUNC_CLEAR;
    in_ch.color_slot <= '0;
    in_ch.shade_slot <= '0;
    in_ch.red <= '0;
    in_ch.green <= '0;
    in_ch.blue <= '0;
    in_ch.alpha <= '0;
    typed_pending <= 1'b0;
    typed_code <= '0;
    foreach (shadow_valid[c, s]) begin
      shadow_valid[c][s] = 1'b0;
      shadow_rgba[c][s] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty palette, transparent pixels, extremes, ties and overwrite
    add_row(pnq_pkg::FUNC_CLASSIFY, 0, 0, 8'hff, 8'hff, 8'hff, 8'hff, 1, 0, 0);
    add_row(pnq_pkg::FUNC_CLASSIFY, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 0);
    add_row(pnq_pkg::FUNC_LOAD, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0);
    add_row(pnq_pkg::FUNC_CLASSIFY, 0, 0, 8'h00, 8'h00, 8'h00, 8'h01, 1, 1, 1);
    add_row(pnq_pkg::FUNC_CLASSIFY, 15, 15, 8'hff, 8'hff, 8'hff, 8'h00, 1, 0, 0);
    add_row(pnq_pkg::FUNC_LOAD, 15, 15, 8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0);
    add_row(pnq_pkg::FUNC_CLASSIFY, 0, 0, 8'hff, 8'hff, 8'hff, 8'hff, 1, 16, 16);
    add_row(pnq_pkg::FUNC_LOAD, 7, 3, 8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0);
    add_row(pnq_pkg::FUNC_CLASSIFY, 0, 0, 8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0);
    add_row(pnq_pkg::FUNC_LOAD, 3, 9, 8'h80, 8'h80, 8'h80, 8'h80, 0, 0, 0);
    add_row(pnq_pkg::FUNC_LOAD, 3, 9, 8'h7f, 8'h81, 8'h7e, 8'h82, 0, 0, 0);
    add_row(pnq_pkg::FUNC_CLASSIFY, 0, 0, 8'h80, 8'h80, 8'h80, 8'h80, 0, 0, 0);
    add_row(FUNC_UNUSED, 15, 15, 8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0);
    add_row(pnq_pkg::FUNC_CLASSIFY, 15, 15, 8'h01, 8'hfe, 8'h00, 8'hff, 0, 0, 0);
    add_row(pnq_pkg::FUNC_CLEAR, 15, 15, 8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0);
    add_row(pnq_pkg::FUNC_CLASSIFY, 0, 0, 8'hff, 8'hff, 8'hff, 8'hff, 1, 0, 0);
    add_row(pnq_pkg::FUNC_LOAD, 0, 15, 8'h00, 8'hff, 8'h00, 8'hff, 0, 0, 0);
    add_row(pnq_pkg::FUNC_LOAD, 15, 0, 8'hff, 8'h00, 8'hff, 8'h01, 0, 0, 0);
    add_row(pnq_pkg::FUNC_CLASSIFY, 0, 0, 8'h00, 8'hff, 8'h00, 8'hff, 1, 1, 16);
    add_row(pnq_pkg::FUNC_CLASSIFY, 0, 0, 8'hff, 8'h00, 8'hff, 8'h01, 0, 0, 0);
    add_row(pnq_pkg::FUNC_CLASSIFY, 0, 0, 8'h80, 8'h80, 8'h80, 8'h01, 0, 0, 0);
    add_row(pnq_pkg::FUNC_CLEAR, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0);
    add_row(pnq_pkg::FUNC_LOAD, 5, 5, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0);
    add_row(pnq_pkg::FUNC_CLASSIFY, 0, 0, 8'h00, 8'h00, 8'h00, 8'h01, 0, 0, 0);

    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].code);
    drain_results();

    // episodes: maybe clear, load some entries, classify pixels, some near them
    sent = 0;
    episode = 0;
    while (sent < RANDOM_WORDS) begin
      coarse = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        w = pixel_word_t'({$urandom, $urandom});
        w.func = pnq_pkg::FUNC_CLEAR;
        send_word(w, 1'b0, '0);
        sent++;
        loaded.delete();
      end
      n_load = (episode == 12) ? pnq_pkg::ENTRIES : $urandom_range(0, 12);
      for (int i = 0; i < n_load; i++) begin
        w.func = pnq_pkg::FUNC_LOAD;
        w.color_slot = (episode == 12) ? pnq_pkg::SLOT_W'(i >> pnq_pkg::SLOT_W)
                                       : pnq_pkg::SLOT_W'($urandom);
        w.shade_slot = (episode == 12) ? pnq_pkg::SLOT_W'(i) : pnq_pkg::SLOT_W'($urandom);
        w.px = pick_rgba(coarse);
        loaded.push_back(w.px);
        send_word(w, 1'b0, '0);
        sent++;
      end
      n_cls = $urandom_range(1, 6);
      for (int i = 0; i < n_cls; i++) begin
        w = pixel_word_t'({$urandom, $urandom});
        w.func = pnq_pkg::FUNC_CLASSIFY;
        if (loaded.size() != 0 && $urandom_range(0, 1) == 0) begin
          e = loaded[$urandom_range(0, loaded.size() - 1)];
          w.px.red = jitter(e.red);
          w.px.green = jitter(e.green);
          w.px.blue = jitter(e.blue);
          w.px.alpha = jitter(e.alpha);
        end else begin
          w.px = pick_rgba(coarse);
        end
        if ($urandom_range(0, 9) == 0) w.px.alpha = '0;
        send_word(w, 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 29) == 0) begin
        w = pixel_word_t'({$urandom, $urandom});
        w.func = FUNC_UNUSED;
        send_word(w, 1'b0, '0);
      end
      if ($urandom_range(0, 19) == 0) drain_results();
      episode++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== palette_nearest_color_quantizer.f =====
hw/rtl/pnq_pkg.sv
hw/rtl/pnq_if.sv
hw/rtl/pnq_ram.sv
hw/rtl/pnq_dist.sv
hw/rtl/palette_nearest_color_quantizer.sv
hw/rtl/pnq_checker.sv
bench/testbench.sv
